// ===== src/pfcm_pkg.sv =====
`default_nettype none

package pfcm_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W = 2;

    // input action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_LE   = 2'd3;

    // check modes
    localparam logic [1:0] CHK_ZERO     = 2'd0;
    localparam logic [1:0] CHK_XOR_DST  = 2'd1;
    localparam logic [1:0] CHK_XOR_HDR  = 2'd2;
    localparam logic [1:0] CHK_SUM16    = 2'd3;

    localparam logic [1:0] CHK_MODE_RST = CHK_XOR_DST;

    // byte slot of the frame being emitted
    typedef enum logic [3:0] {
        ST_HDR0 = 4'd0,
        ST_HDR1 = 4'd1,
        ST_DST  = 4'd2,
        ST_SRC  = 4'd3,
        ST_ID0  = 4'd4,
        ST_ID1  = 4'd5,
        ST_CMD  = 4'd6,
        ST_CNT  = 4'd7,
        ST_PAY  = 4'd8,
        ST_CK0  = 4'd9,
        ST_CK1  = 4'd10,
        ST_TR0  = 4'd11,
        ST_TR1  = 4'd12
    } t_step;

    // control from the sequencer to the check unit
    typedef struct packed {
        logic              clr;
        logic              add;
        logic [BYTE_W-1:0] data;
    } t_acc_ctrl;

endpackage

`default_nettype wire

// ===== src/pfcm_in_if.sv =====
`default_nettype none

interface pfcm_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  dest_node;
    logic [7:0]  source_node;
    logic [15:0] packet_id;
    logic [7:0]  command;
    logic [7:0]  payload_count;
    logic [7:0]  payload_byte;

    modport source (
        output valid, action, dest_node, source_node, packet_id, command,
               payload_count, payload_byte,
        input  ready
    );

    modport sink (
        input  valid, action, dest_node, source_node, packet_id, command,
               payload_count, payload_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pfcm_out_if.sv =====
`default_nettype none

interface pfcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;

    modport source (
        output valid, frame_byte, frame_end, run_last,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, frame_end, run_last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pfcm_check.sv =====
`default_nettype none

// Running XOR / sum16 over checked bytes, and the two check bytes.
module pfcm_check (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pfcm_pkg::t_acc_ctrl              i_ctrl,
    input  wire  [1:0]                       i_mode,
    input  wire  [pfcm_pkg::WORD_W-1:0]      i_header_word,
    output logic [pfcm_pkg::BYTE_W-1:0]      o_ck0,
    output logic [pfcm_pkg::BYTE_W-1:0]      o_ck1
);

    logic [pfcm_pkg::BYTE_W-1:0] r_xor;
    logic [pfcm_pkg::WORD_W-1:0] r_sum;
    logic [pfcm_pkg::BYTE_W-1:0] hdr_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor <= '0;
            r_sum <= '0;
        end else if (i_ctrl.clr) begin
            r_xor <= '0;
            r_sum <= '0;
        end else if (i_ctrl.add) begin
            r_xor <= r_xor ^ i_ctrl.data;
            r_sum <= r_sum + {{(pfcm_pkg::WORD_W-pfcm_pkg::BYTE_W){1'b0}}, i_ctrl.data};
        end
    end

    assign hdr_x = i_header_word[pfcm_pkg::WORD_W-1:pfcm_pkg::BYTE_W]
                 ^ i_header_word[pfcm_pkg::BYTE_W-1:0];

    always_comb begin
        unique case (i_mode)
            pfcm_pkg::CHK_ZERO: begin
                o_ck0 = '0;
                o_ck1 = '0;
            end
            pfcm_pkg::CHK_XOR_DST: begin
                o_ck0 = r_xor;
                o_ck1 = r_xor;
            end
            pfcm_pkg::CHK_XOR_HDR: begin
                o_ck0 = r_xor ^ hdr_x;
                o_ck1 = r_xor ^ hdr_x;
            end
            pfcm_pkg::CHK_SUM16: begin
                o_ck0 = r_sum[pfcm_pkg::WORD_W-1:pfcm_pkg::BYTE_W];
                o_ck1 = r_sum[pfcm_pkg::BYTE_W-1:0];
            end
            default: begin
                o_ck0 = '0;
                o_ck1 = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/packet_framer_with_check_modes_core.sv =====
`default_nettype none

// Channel   Dir  Beat carries
// --------  ---  ---------------------------------------------------------
// i_req     in   action, dest_node, source_node, packet_id, command,
//                payload_count, payload_byte
// o_frm     out  frame_byte, frame_end, run_last
// i_cfg_*   in   write enable, register index, 16-bit write data
//
// One frame byte leaves per cycle. A payload beat inside a frame gives one
// byte and the next beat is taken in the same cycle; a start beat holds the
// item register from HDR0 to CNT, on through the tail if its count is zero,
// as does a closing payload beat from PAY on. A payload beat outside a
// frame is dropped. Reset (synchronous, active low) closes any frame and
// restores the register defaults. A stall on o_frm freezes the sequencer;
// i_req is still taken while the item register is free or finishing.
module packet_framer_with_check_modes_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    pfcm_in_if.sink                            i_req,
    pfcm_out_if.source                         o_frm,
    input  wire                                i_cfg_we,
    input  wire  [pfcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [pfcm_pkg::WORD_W-1:0]        i_cfg_data
);

    // configuration registers
    logic [pfcm_pkg::WORD_W-1:0] r_header_word;
    logic [pfcm_pkg::WORD_W-1:0] r_trailer_word;
    logic [1:0]                  r_check_mode;
    logic                        r_id_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_word  <= '0;
            r_trailer_word <= '0;
            r_check_mode   <= pfcm_pkg::CHK_MODE_RST;
            r_id_le        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfcm_pkg::REG_HEADER:  r_header_word  <= i_cfg_data;
                pfcm_pkg::REG_TRAILER: r_trailer_word <= i_cfg_data;
                pfcm_pkg::REG_CHECK:   r_check_mode   <= i_cfg_data[1:0];
                pfcm_pkg::REG_ID_LE:   r_id_le        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item register: the beat being turned into frame bytes
    logic        r_busy;
    logic [7:0]  r_dst;
    logic [7:0]  r_src;
    logic [15:0] r_pid;
    logic [7:0]  r_cmd;
    logic [7:0]  r_cnt;
    logic [7:0]  r_pay;

    pfcm_pkg::t_step r_step, n_step;

    // frame state
    logic       r_in_frame;
    logic [7:0] r_bytes_left;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_last;

    logic load, emit, drop, finish, last;
    logic [7:0] cur_byte;
    logic       checked;
    logic [7:0] ck0, ck1;
    pfcm_pkg::t_acc_ctrl acc_ctrl;

    // payload beat with no open frame: nothing to send
    assign drop   = r_busy && (r_step == pfcm_pkg::ST_PAY) && !r_in_frame;
    assign emit   = r_busy && !drop && (!r_out_valid || o_frm.ready);
    assign finish = drop || (emit && last);
    assign i_req.ready = !r_busy || finish;
    assign load   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dst    <= i_req.dest_node;
            r_src    <= i_req.source_node;
            r_pid    <= i_req.packet_id;
            r_cmd    <= i_req.command;
            r_cnt    <= i_req.payload_count;
            r_pay    <= i_req.payload_byte;
        end
    end

    // next slot
    always_comb begin
        n_step = r_step;
        if (load) begin
            n_step = (i_req.action == pfcm_pkg::ACT_PAYLOAD) ? pfcm_pkg::ST_PAY
                                                             : pfcm_pkg::ST_HDR0;
        end else if (emit) begin
            unique case (r_step)
                pfcm_pkg::ST_HDR0: n_step = pfcm_pkg::ST_HDR1;
                pfcm_pkg::ST_HDR1: n_step = pfcm_pkg::ST_DST;
                pfcm_pkg::ST_DST:  n_step = pfcm_pkg::ST_SRC;
                pfcm_pkg::ST_SRC:  n_step = pfcm_pkg::ST_ID0;
                pfcm_pkg::ST_ID0:  n_step = pfcm_pkg::ST_ID1;
                pfcm_pkg::ST_ID1:  n_step = pfcm_pkg::ST_CMD;
                pfcm_pkg::ST_CMD:  n_step = pfcm_pkg::ST_CNT;
                pfcm_pkg::ST_CNT:  n_step = (r_cnt == 8'd0) ? pfcm_pkg::ST_CK0 : r_step;
                pfcm_pkg::ST_PAY:  n_step = (r_bytes_left == 8'd1) ? pfcm_pkg::ST_CK0
                                                                     : r_step;
                pfcm_pkg::ST_CK0:  n_step = pfcm_pkg::ST_CK1;
                pfcm_pkg::ST_CK1:  n_step = pfcm_pkg::ST_TR0;
                pfcm_pkg::ST_TR0:  n_step = pfcm_pkg::ST_TR1;
                pfcm_pkg::ST_TR1:  n_step = r_step;
                default:           n_step = r_step;
            endcase
        end
    end

    // byte for the current slot
    always_comb begin
        cur_byte = '0;
        checked  = 1'b0;
        last     = 1'b0;
        unique case (r_step)
            pfcm_pkg::ST_HDR0: cur_byte = r_header_word[15:8];
            pfcm_pkg::ST_HDR1: cur_byte = r_header_word[7:0];
            pfcm_pkg::ST_DST: begin
                cur_byte = r_dst;
                checked  = 1'b1;
            end
            pfcm_pkg::ST_SRC: begin
                cur_byte = r_src;
                checked  = 1'b1;
            end
            pfcm_pkg::ST_ID0: begin
                cur_byte = r_id_le ? r_pid[7:0] : r_pid[15:8];
                checked  = 1'b1;
            end
            pfcm_pkg::ST_ID1: begin
                cur_byte = r_id_le ? r_pid[15:8] : r_pid[7:0];
                checked  = 1'b1;
            end
            pfcm_pkg::ST_CMD: begin
                cur_byte = r_cmd;
                checked  = 1'b1;
            end
            pfcm_pkg::ST_CNT: begin
                cur_byte = r_cnt;
                checked  = 1'b1;
                last     = (r_cnt != 8'd0);
            end
            pfcm_pkg::ST_PAY: begin
                cur_byte = r_pay;
                checked  = 1'b1;
                last     = (r_bytes_left != 8'd1);
            end
            pfcm_pkg::ST_CK0: cur_byte = ck0;
            pfcm_pkg::ST_CK1: cur_byte = ck1;
            pfcm_pkg::ST_TR0: cur_byte = r_trailer_word[15:8];
            pfcm_pkg::ST_TR1: begin
                cur_byte = r_trailer_word[7:0];
                last     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= pfcm_pkg::ST_HDR0;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end

            if (emit) begin
                if (r_step == pfcm_pkg::ST_CNT && r_cnt != 8'd0) begin
                    r_in_frame   <= 1'b1;
                    r_bytes_left <= r_cnt;
                end else if (r_step == pfcm_pkg::ST_PAY) begin
                    r_bytes_left <= r_bytes_left - 8'd1;
                end else if (r_step == pfcm_pkg::ST_TR1) begin
                    r_in_frame   <= 1'b0;
                    r_bytes_left <= '0;
                end
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_frm.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_end  <= (r_step == pfcm_pkg::ST_TR1);
            r_out_last <= last;
        end
    end

    // accumulators restart with each frame's first header byte
    assign acc_ctrl.clr  = emit && (r_step == pfcm_pkg::ST_HDR0);
    assign acc_ctrl.add  = emit && checked;
    assign acc_ctrl.data = cur_byte;

    pfcm_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (acc_ctrl),
        .i_mode        (r_check_mode),
        .i_header_word (r_header_word),
        .o_ck0         (ck0),
        .o_ck1         (ck1)
    );

    assign o_frm.valid      = r_out_valid;
    assign o_frm.frame_byte = r_out_byte;
    assign o_frm.frame_end  = r_out_end;
    assign o_frm.run_last   = r_out_last;

    // frame end closes the beat's run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_last)
        else $error("frame end without run last");

    // frame already closed while its last trailer byte waits
    a_end_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> !r_in_frame)
        else $error("frame still open after trailer");

    // no leftover count without an open frame
    a_left_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_bytes_left == 8'd0))
        else $error("bytes left outside a frame");

    // check bytes go out as a pair
    a_ck_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (r_step == pfcm_pkg::ST_CK0) |=> r_busy && (r_step == pfcm_pkg::ST_CK1))
        else $error("second check byte skipped");

endmodule

`default_nettype wire

// ===== dv/tb_packet_framer_with_check_modes_core.sv =====
`timescale 1ns / 100ps

// Framer bench: a short directed plan, then random framed traffic over several
// register settings.
// Every accepted request beat is run through a local copy of the framer; the
// bytes it yields (or typed ones) are queued and matched against o_frm in order.
module tb_packet_framer_with_check_modes_core;

    localparam int LIMIT_CYC   = 100000;  // watchdog, far above the slowest legal run
    localparam int SETTLE_CYC  = 16;      // settle wait after the owed bytes are out
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 11;

    // one request beat
    typedef struct packed {
        logic                        action;
        logic [pfcm_pkg::BYTE_W-1:0] dest;
        logic [pfcm_pkg::BYTE_W-1:0] src;
        logic [pfcm_pkg::WORD_W-1:0] pkt_id;
        logic [pfcm_pkg::BYTE_W-1:0] cmd;
        logic [pfcm_pkg::BYTE_W-1:0] n_pay;
        logic [pfcm_pkg::BYTE_W-1:0] pay;
    } t_req;

    // one frame byte as it leaves the core
    typedef struct packed {
        logic [pfcm_pkg::BYTE_W-1:0] data;
        logic                        fend;
        logic                        flast;
    } t_beat;

    // plan row: a register write or a request, optionally with bytes typed in
    typedef struct packed {
        logic                           is_cfg;
        logic [pfcm_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [pfcm_pkg::WORD_W-1:0]    cfg_data;
        t_req                           req;
        logic                           typed;
        logic [3:0]                     exp_n;
        logic                           exp_close;
        logic [95:0]                    exp_bytes;  // first byte in the top octet
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pfcm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [pfcm_pkg::WORD_W-1:0]    i_cfg_data;
    logic rx_rdy  = 1'b0;

    pfcm_in_if  req_if ();
    pfcm_out_if frm_if ();

    assign frm_if.ready = rx_rdy;

    packet_framer_with_check_modes_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_frm      (frm_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Local framer: registers and running frame state
    // ---------------------------------------------------------------------
    logic [pfcm_pkg::WORD_W-1:0] hdr_word = '0;
    logic [pfcm_pkg::WORD_W-1:0] trl_word = '0;
    logic [1:0]                  chk_sel  = pfcm_pkg::CHK_MODE_RST;
    logic                        id_swap  = 1'b0;
    logic                        frm_open = 1'b0;
    logic [pfcm_pkg::BYTE_W-1:0] pay_left = '0;
    logic [pfcm_pkg::BYTE_W-1:0] xor_run  = '0;
    logic [pfcm_pkg::WORD_W-1:0] sum_run  = '0;

    t_beat step_beats[$];   // bytes caused by the beat just taken
    t_beat frame_q[$];      // bytes still owed by the core
    t_row  drv_q[$];        // rows driven but not yet taken

    int errs          = 0;
    int beats_in      = 0;
    int dropped       = 0;
    int beats_out     = 0;
    int frames_closed = 0;
    int cyc           = 0;

    // receiver stall pattern, rotated one bit per cycle
    logic [15:0] rx_pat = 16'hFFFF;
    logic [3:0]  rx_ph  = '0;

    // sender bursts
    int burst_left = 0;
    int gap_max    = 2;

    task automatic put_beat(input logic [pfcm_pkg::BYTE_W-1:0] b, input logic fe,
                            input logic cov);
        if (cov) begin
            xor_run = xor_run ^ b;
            sum_run = sum_run + {8'h00, b};
        end
        step_beats.push_back('{data: b, fend: fe, flast: 1'b0});
    endtask

    // check bytes use the mode and header in force now, not at the start beat
    task automatic put_close();
        logic [pfcm_pkg::BYTE_W-1:0] c0;
        logic [pfcm_pkg::BYTE_W-1:0] c1;
        c0 = 8'h00;
        c1 = 8'h00;
        case (chk_sel)
            pfcm_pkg::CHK_XOR_DST: begin
                c0 = xor_run;
                c1 = xor_run;
            end
            pfcm_pkg::CHK_XOR_HDR: begin
                c0 = xor_run ^ hdr_word[15:8] ^ hdr_word[7:0];
                c1 = c0;
            end
            pfcm_pkg::CHK_SUM16: begin
                c0 = sum_run[15:8];
                c1 = sum_run[7:0];
            end
            default: ;
        endcase
        put_beat(c0, 1'b0, 1'b0);
        put_beat(c1, 1'b0, 1'b0);
        put_beat(trl_word[15:8], 1'b0, 1'b0);
        put_beat(trl_word[7:0], 1'b1, 1'b0);
        frm_open = 1'b0;
        pay_left = '0;
    endtask

    task automatic frame_step(input t_req r);
        step_beats.delete();
        if (r.action == pfcm_pkg::ACT_START) begin
            // a start inside an open frame simply throws the old one away
            xor_run = '0;
            sum_run = '0;
            put_beat(hdr_word[15:8], 1'b0, 1'b0);
            put_beat(hdr_word[7:0], 1'b0, 1'b0);
            put_beat(r.dest, 1'b0, 1'b1);
            put_beat(r.src, 1'b0, 1'b1);
            if (id_swap) begin
                put_beat(r.pkt_id[7:0], 1'b0, 1'b1);
                put_beat(r.pkt_id[15:8], 1'b0, 1'b1);
            end else begin
                put_beat(r.pkt_id[15:8], 1'b0, 1'b1);
                put_beat(r.pkt_id[7:0], 1'b0, 1'b1);
            end
            put_beat(r.cmd, 1'b0, 1'b1);
            put_beat(r.n_pay, 1'b0, 1'b1);
            if (r.n_pay == 8'd0) begin
                put_close();
            end else begin
                frm_open = 1'b1;
                pay_left = r.n_pay;
            end
        end else if (frm_open) begin
            put_beat(r.pay, 1'b0, 1'b1);
            pay_left = pay_left - 8'd1;
            if (pay_left == 8'd0) begin
                put_close();
            end
        end
        // payload with no open frame: nothing
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].flast = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------------
    // Plan rows
    // ---------------------------------------------------------------------
    function automatic t_row item_row(input logic act, input logic [7:0] d, input logic [7:0] s,
                                      input logic [15:0] id, input logic [7:0] c,
                                      input logic [7:0] n, input logic [7:0] p);
        t_row w;
        w = '0;
        w.req = '{action: act, dest: d, src: s, pkt_id: id, cmd: c, n_pay: n, pay: p};
        return w;
    endfunction

    function automatic t_row cfg_row(input logic [pfcm_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [15:0] v);
        t_row w;
        w = '0;
        w.is_cfg   = 1'b1;
        w.cfg_idx  = idx;
        w.cfg_data = v;
        return w;
    endfunction

    function automatic t_row with_exp(input t_row w, input logic [3:0] n, input logic cl,
                                      input logic [95:0] b);
        t_row o;
        o = w;
        o.typed     = 1'b1;
        o.exp_n     = n;
        o.exp_close = cl;
        o.exp_bytes = b;
        return o;
    endfunction

    function automatic t_row req_row(input t_req r);
        t_row w;
        w = '0;
        w.req = r;
        return w;
    endfunction

    function automatic t_req rand_req(input logic act);
        t_req r;
        r.action = act;
        r.dest   = 8'($urandom);
        r.src    = 8'($urandom);
        r.pkt_id = 16'($urandom);
        r.cmd    = 8'($urandom);
        r.n_pay  = 8'($urandom);
        r.pay    = 8'($urandom);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_rdy <= rx_pat[rx_ph];
        rx_ph  <= rx_ph + 4'd1;
    end

    // bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // valid stays high across back-to-back beats; only pace/wait_idle drop it
    task automatic send_row(input t_row w);
        pace();
        drv_q.push_back(w);
        req_if.valid         <= 1'b1;
        req_if.action        <= w.req.action;
        req_if.dest_node     <= w.req.dest;
        req_if.source_node   <= w.req.src;
        req_if.packet_id     <= w.req.pkt_id;
        req_if.command       <= w.req.cmd;
        req_if.payload_count <= w.req.n_pay;
        req_if.payload_byte  <= w.req.pay;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // all owed bytes out, then room for a dropped beat still in the core
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (frame_q.size() != 0 || drv_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // leaves the write enable high so writes can go back to back
    task automatic write_reg(input logic [pfcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pfcm_pkg::WORD_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            pfcm_pkg::REG_HEADER:  hdr_word = val;
            pfcm_pkg::REG_TRAILER: trl_word = val;
            pfcm_pkg::REG_CHECK:   chk_sel  = val[1:0];
            pfcm_pkg::REG_ID_LE:   id_swap  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] h, input logic [15:0] t, input logic [1:0] m,
                            input logic le);
        wait_idle();
        write_reg(pfcm_pkg::REG_HEADER, h);
        write_reg(pfcm_pkg::REG_TRAILER, t);
        write_reg(pfcm_pkg::REG_CHECK, {14'd0, m});
        write_reg(pfcm_pkg::REG_ID_LE, {15'd0, le});
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Monitor: take request beats into the model, then check frame beats.
    // Both in one process so a same-edge push/pop can never race.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_row  acc;
        t_req  rq;
        t_beat want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                acc       = drv_q.pop_front();
                rq.action = req_if.action;
                rq.dest   = req_if.dest_node;
                rq.src    = req_if.source_node;
                rq.pkt_id = req_if.packet_id;
                rq.cmd    = req_if.command;
                rq.n_pay  = req_if.payload_count;
                rq.pay    = req_if.payload_byte;
                frame_step(rq);
                beats_in++;
                if (step_beats.size() == 0) begin
                    dropped++;
                end
                if (acc.typed) begin
                    // hand-written bytes; model still ran to keep its state
                    for (int j = 0; j < acc.exp_n; j++) begin
                        want.data  = acc.exp_bytes[95 - 8 * j -: 8];
                        want.flast = (j == acc.exp_n - 1);
                        want.fend  = acc.exp_close && want.flast;
                        frame_q.push_back(want);
                    end
                end else begin
                    foreach (step_beats[j]) frame_q.push_back(step_beats[j]);
                end
            end

            if (frm_if.valid && frm_if.ready) begin
                beats_out++;
                if (frm_if.frame_end === 1'b1) begin
                    frames_closed++;
                end
                if (frame_q.size() == 0) begin
                    $display("%0t: frame beat with nothing owed: byte %02h end %0b last %0b",
                             $time, frm_if.frame_byte, frm_if.frame_end, frm_if.run_last);
                    errs++;
                end else begin
                    want = frame_q.pop_front();
                    if (frm_if.frame_byte !== want.data) begin
                        $display("%0t: frame_byte expected %02h got %02h",
                                 $time, want.data, frm_if.frame_byte);
                        errs++;
                    end
                    if (frm_if.frame_end !== want.fend) begin
                        $display("%0t: frame_end expected %0b got %0b",
                                 $time, want.fend, frm_if.frame_end);
                        errs++;
                    end
                    if (frm_if.run_last !== want.flast) begin
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, want.flast, frm_if.run_last);
                        errs++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("%0t: watchdog expired, %0d frame bytes still owed", $time, frame_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        t_row plan[$];
        t_req r;
        bit   cfg_busy;
        int   n;
        int   pick;
        int   sent;
        int   gen_left;

        cfg_busy = 1'b0;
        gen_left = 0;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= pfcm_pkg::REG_HEADER;
        i_cfg_data           <= '0;
        req_if.valid         <= 1'b0;
        req_if.action        <= pfcm_pkg::ACT_START;
        req_if.dest_node     <= '0;
        req_if.source_node   <= '0;
        req_if.packet_id     <= '0;
        req_if.command       <= '0;
        req_if.payload_count <= '0;
        req_if.payload_byte  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed plan ---
        // reset defaults: zero header/trailer, xor from dest, id high byte first
        plan.push_back(with_exp(item_row(pfcm_pkg::ACT_START, 8'h00, 8'h00, 16'h0000, 8'h00,
                                         8'h00, 8'h00), 4'd12, 1'b1, 96'h0));
        plan.push_back(cfg_row(pfcm_pkg::REG_HEADER, 16'hFFFF));
        plan.push_back(cfg_row(pfcm_pkg::REG_TRAILER, 16'hFFFF));
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_ZERO}));
        plan.push_back(with_exp(item_row(pfcm_pkg::ACT_START, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                         8'h00, 8'hFF), 4'd12, 1'b1,
                                96'hFFFF_FFFF_FFFF_FF00_0000_FFFF));
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_XOR_DST}));
        // five FF bytes and a zero count fold to FF
        plan.push_back(with_exp(item_row(pfcm_pkg::ACT_START, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                         8'h00, 8'h00), 4'd12, 1'b1,
                                96'hFFFF_FFFF_FFFF_FF00_FFFF_FFFF));
        // payload with no frame open: dropped
        plan.push_back(with_exp(item_row(pfcm_pkg::ACT_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                         8'hFF, 8'hFF), 4'd0, 1'b0, 96'h0));
        plan.push_back(cfg_row(pfcm_pkg::REG_HEADER, 16'hA53C));
        plan.push_back(cfg_row(pfcm_pkg::REG_TRAILER, 16'h0FF0));
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_XOR_HDR}));
        plan.push_back(item_row(pfcm_pkg::ACT_START, 8'h12, 8'h34, 16'h1234, 8'h56, 8'h01,
                                8'h00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h9A));
        plan.push_back(cfg_row(pfcm_pkg::REG_ID_LE, 16'h0001));
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_SUM16}));
        plan.push_back(item_row(pfcm_pkg::ACT_START, 8'hFF, 8'hFF, 16'hABCD, 8'h80, 8'h02,
                                8'h00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'hFF));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h01));
        // long frame left open, then a fresh start abandons it
        plan.push_back(item_row(pfcm_pkg::ACT_START, 8'h3C, 8'hC3, 16'h0001, 8'h7E, 8'hFF,
                                8'h00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h7F));
        plan.push_back(item_row(pfcm_pkg::ACT_START, 8'h01, 8'h02, 16'h8000, 8'h03, 8'h03,
                                8'h00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h11));
        // registers rewritten mid-frame: the tail uses the new values
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_XOR_DST}));
        plan.push_back(cfg_row(pfcm_pkg::REG_TRAILER, 16'h1234));
        plan.push_back(cfg_row(pfcm_pkg::REG_ID_LE, 16'h0000));
        plan.push_back(cfg_row(pfcm_pkg::REG_HEADER, 16'h0000));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h22));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'h33));
        // header folded into the check is the one in force at the tail
        plan.push_back(cfg_row(pfcm_pkg::REG_CHECK, {14'd0, pfcm_pkg::CHK_XOR_HDR}));
        plan.push_back(item_row(pfcm_pkg::ACT_START, 8'hAA, 8'h55, 16'h00FF, 8'h0F, 8'h01,
                                8'h00));
        plan.push_back(cfg_row(pfcm_pkg::REG_HEADER, 16'hFF00));
        plan.push_back(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00,
                                8'hE7));
        plan.push_back(with_exp(item_row(pfcm_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00,
                                         8'h00, 8'h55), 4'd0, 1'b0, 96'h0));

        for (int k = 0; k < plan.size(); k++) begin
            if (plan[k].is_cfg) begin
                if (!cfg_busy) begin
                    wait_idle();
                    cfg_busy = 1'b1;
                end
                write_reg(plan[k].cfg_idx, plan[k].cfg_data);
            end else begin
                if (cfg_busy) begin
                    i_cfg_we <= 1'b0;
                    cfg_busy = 1'b0;
                end
                send_row(plan[k]);
            end
        end

        // --- random phases ---
        // phase 0: no stalls either side, extreme words; later phases stall
        for (int p = 0; p < N_PHASES; p++) begin
            rx_pat  = (p == 0) ? 16'hFFFF :
                      (p == 3) ? (16'($urandom) & 16'($urandom)) | 16'h0001 :
                                 16'($urandom) | 16'h0001;
            gap_max = (p == 0) ? 0 : (p % 3) + 2;
            set_regs((p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom),
                     (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom),
                     2'(p), 1'(p >> 1));
            gen_left = 0;
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick == 8) begin
                    // noise: stray payloads, dropped unless a broken frame is open
                    repeat ($urandom_range(1, 3)) begin
                        if (gen_left > 0) begin
                            n++;
                            gen_left--;
                        end
                        send_row(req_row(rand_req(pfcm_pkg::ACT_PAYLOAD)));
                    end
                end else begin
                    r = rand_req(pfcm_pkg::ACT_START);
                    if (pick == 7) begin
                        r.n_pay = 8'($urandom_range(1, 255));   // cut short below
                    end else if (pick == 9) begin
                        r.n_pay = 8'($urandom_range(6, 12));
                    end else begin
                        r.n_pay = 8'($urandom_range(0, 5));
                    end
                    send_row(req_row(r));
                    n++;
                    gen_left = r.n_pay;
                    sent = (pick != 7) ? gen_left :
                           $urandom_range(0, (gen_left > 5) ? 4 : gen_left - 1);
                    repeat (sent) begin
                        send_row(req_row(rand_req(pfcm_pkg::ACT_PAYLOAD)));
                        n++;
                        gen_left--;
                    end
                end
            end
        end

        wait_idle();
        if (frame_q.size() != 0) begin
            $display("%0t: %0d frame bytes never arrived", $time, frame_q.size());
            errs++;
        end

        $display("Run took %0d request beats (%0d dropped outside a frame), %0d frame bytes,",
                 beats_in, dropped, beats_out);
        $display("%0d closed frames across all check modes, id orders and stall patterns.",
                 frames_closed);
        if (errs == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
